### rtl/page_replacement_with_swap_top_macros.svh
// Assertion macros shared by the page replacement block.
`ifndef PAGE_REPLACEMENT_WITH_SWAP_TOP_MACROS_SVH
`define PAGE_REPLACEMENT_WITH_SWAP_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PRA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pra_pkg.sv
// Shared types, codes and constants of the page replacement block.
package pra_pkg;

	// Highest valid page number
	localparam int PAGE_COUNT = 255;
	// Default number of queue cells
	localparam int MAX_RESIDENT_DEF = 16;

	// Page place store geometry
	localparam int PAGE_W = 8;
	localparam int PLACE_DEPTH = 256;

	// Page place codes
	localparam logic [1:0] PLACE_NEVER = 2'd0;
	localparam logic [1:0] PLACE_RESIDENT = 2'd1;
	localparam logic [1:0] PLACE_SWAPPED = 2'd2;

	// Replacement policy codes (unused code behaves as FIFO)
	localparam logic [1:0] MODE_FIFO = 2'd0;
	localparam logic [1:0] MODE_LRU = 2'd1;
	localparam logic [1:0] MODE_RANDOM = 2'd2;

	// Result outcome codes
	localparam logic [1:0] OUT_HIT = 2'd0;
	localparam logic [1:0] OUT_FILL = 2'd1;
	localparam logic [1:0] OUT_EVICT = 2'd2;
	localparam logic [1:0] OUT_ERROR = 2'd3;

	// Register indexes
	localparam logic [1:0] REG_RESIDENT_LIMIT = 2'd0;
	localparam logic [1:0] REG_SWAP_LIMIT = 2'd1;
	localparam logic [1:0] REG_REPLACE_MODE = 2'd2;

	// Register reset values
	localparam logic [4:0] RESIDENT_LIMIT_RST = 5'd16;
	localparam logic [7:0] SWAP_LIMIT_RST = 8'd255;
	localparam logic [1:0] REPLACE_MODE_RST = MODE_FIFO;

	// Victim LFSR
	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	// Fault counter
	localparam logic [15:0] FAULT_MAX = 16'hFFFF;

	// Remainder unit: one dividend bit per cycle
	localparam int MOD_STEPS = 16;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_DIV,
		ST_EVICT,
		ST_FILL
	} state_t;

	// Page place store write
	typedef struct packed {
		logic en;
		logic [PAGE_W-1:0] addr;
		logic [1:0] place;
	} pmem_wr_t;

	// Resident queue command
	typedef struct packed {
		logic push;
		logic shift;
		logic [PAGE_W-1:0] page;
	} qcmd_t;

endpackage

### rtl/page_replacement_with_swap_top.sv
// Top level of the page replacement block with swap tracking.
//
//  Channel  Dir  Handshake          Payload
//  in       in   in_valid/in_ready  page_number
//  out      out  out_valid/out_ready outcome, evicted_page, fault_total
//  cfg      in   APB psel/penable   paddr, pwdata, prdata
//
// A hit, a free-frame fill, an error or an ignored page is accepted with the
// page place read, then decided. FIFO and LRU eviction go on through the evict
// and fill states; random eviction first waits on the remainder unit.
// One request is in flight at a time; the result register frees the input side.
// Reset clears place valid bits, queue count, counters, halt flag; seeds LFSR.
// A stalled result holds the sequencer in its final state until taken.
module page_replacement_with_swap_top
	import pra_pkg::*;
#(
	parameter int MAX_RESIDENT = MAX_RESIDENT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] page_number,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] outcome,
	output logic [7:0] evicted_page,
	output logic [15:0] fault_total,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	`include "page_replacement_with_swap_top_macros.svh"

	localparam int CW = $clog2(MAX_RESIDENT + 1);
	localparam int IW = (MAX_RESIDENT > 1) ? $clog2(MAX_RESIDENT) : 1;
	localparam int LW = (CW > 5) ? CW : 5;

	state_t state_q, state_nxt;

	logic [4:0] resident_limit_q;
	logic [7:0] swap_limit_q;
	logic [1:0] replace_mode_q;
	logic [7:0] page_q;
	logic [7:0] swap_cnt_q;
	logic [15:0] fault_q;
	logic [15:0] lfsr_q;
	logic [15:0] lfsr_nxt;
	logic halted_q;
	logic [IW-1:0] idx_q;
	logic [7:0] victim_q;
	logic out_valid_q;
	logic [1:0] outcome_q;
	logic [7:0] evicted_q;
	logic [15:0] fault_out_q;

	logic cfg_wr;
	logic [1:0] place;
	pmem_wr_t mem_wr;
	qcmd_t qcmd;
	logic [IW-1:0] q_idx;
	logic [CW-1:0] q_count;
	logic q_hit;
	logic [IW-1:0] q_match_idx;
	logic [7:0] q_sel_page;
	logic mod_start;
	logic mod_done;
	logic [IW-1:0] mod_rem;

	logic [4:0] lim_raw;
	logic [LW-1:0] frame_lim;
	logic mem_full;
	logic swap_full;
	logic in_range;
	logic lk_err;
	logic lk_evict;
	logic out_free;

	logic commit;
	logic [1:0] res_outcome;
	logic [7:0] res_evicted;
	logic fault_inc;
	logic halt_set;
	logic lfsr_step;
	logic idx_zero;
	logic swap_inc;
	logic victim_load;
	logic [15:0] fault_nxt;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resident_limit_q <= RESIDENT_LIMIT_RST;
			swap_limit_q <= SWAP_LIMIT_RST;
			replace_mode_q <= REPLACE_MODE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_RESIDENT_LIMIT: resident_limit_q <= pwdata[4:0];
				REG_SWAP_LIMIT: swap_limit_q <= pwdata[7:0];
				REG_REPLACE_MODE: replace_mode_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_RESIDENT_LIMIT: prdata = {27'd0, resident_limit_q};
			REG_SWAP_LIMIT: prdata = {24'd0, swap_limit_q};
			REG_REPLACE_MODE: prdata = {30'd0, replace_mode_q};
			default: prdata = '0;
		endcase
	end

	// Storage units
	pra_place_mem u_place (
		.clk (clk),
		.arst_n (arst_n),
		.rd_en (in_valid && in_ready),
		.rd_addr (page_number),
		.rd_place (place),
		.wr (mem_wr)
	);

	pra_queue #(
		.MAX_RESIDENT (MAX_RESIDENT)
	) u_queue (
		.clk (clk),
		.arst_n (arst_n),
		.cmd (qcmd),
		.idx (q_idx),
		.count (q_count),
		.match_hit (q_hit),
		.match_idx (q_match_idx),
		.sel_page (q_sel_page)
	);

	pra_mod #(
		.MAX_RESIDENT (MAX_RESIDENT)
	) u_mod (
		.clk (clk),
		.arst_n (arst_n),
		.start (mod_start),
		.dividend (lfsr_nxt),
		.divisor (q_count),
		.done (mod_done),
		.rem (mod_rem)
	);

	// Limits and lookup decode
	assign lim_raw = (resident_limit_q == 5'd0) ? 5'd1 : resident_limit_q;
	assign frame_lim = (LW'(lim_raw) > LW'(MAX_RESIDENT)) ? LW'(MAX_RESIDENT) : LW'(lim_raw);
	assign mem_full = LW'(q_count) >= frame_lim;
	assign swap_full = swap_cnt_q >= swap_limit_q;
	assign in_range = page_q != 8'd0 && 16'(page_q) <= 16'(PAGE_COUNT);
	assign lk_err = place != PLACE_RESIDENT && place != PLACE_SWAPPED && mem_full && swap_full;
	assign lk_evict = !halted_q && in_range && place != PLACE_RESIDENT && !lk_err && mem_full;
	assign out_free = !out_valid_q || out_ready;

	assign lfsr_nxt = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? LFSR_TAPS : 16'd0);
	assign q_idx = (state_q == ST_LOOK) ? q_match_idx : idx_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_LOOK;
			end
			ST_LOOK: begin
				if (lk_evict) begin
					state_nxt = (replace_mode_q == MODE_RANDOM) ? ST_DIV : ST_EVICT;
				end else if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (mod_done) state_nxt = ST_EVICT;
			end
			ST_EVICT: state_nxt = ST_FILL;
			ST_FILL: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		commit = 1'b0;
		res_outcome = OUT_HIT;
		res_evicted = 8'd0;
		fault_inc = 1'b0;
		halt_set = 1'b0;
		lfsr_step = 1'b0;
		mod_start = 1'b0;
		idx_zero = 1'b0;
		swap_inc = 1'b0;
		victim_load = 1'b0;
		mem_wr = '0;
		qcmd = '0;
		qcmd.page = page_q;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_LOOK: begin
				if (halted_q) begin
					commit = out_free;
					res_outcome = OUT_ERROR;
				end else if (!in_range) begin
					commit = out_free;
				end else if (place == PLACE_RESIDENT) begin
					commit = out_free;
					qcmd.shift = out_free && replace_mode_q == MODE_LRU && q_hit;
				end else if (lk_err) begin
					commit = out_free;
					res_outcome = OUT_ERROR;
					halt_set = out_free;
				end else if (!mem_full) begin
					commit = out_free;
					res_outcome = OUT_FILL;
					fault_inc = out_free;
					qcmd.push = out_free;
					mem_wr.en = out_free;
					mem_wr.addr = page_q;
					mem_wr.place = PLACE_RESIDENT;
				end else if (replace_mode_q == MODE_RANDOM) begin
					lfsr_step = 1'b1;
					mod_start = 1'b1;
				end else begin
					idx_zero = 1'b1;
				end
			end
			ST_EVICT: begin
				// victim to swap, page joins the back
				mem_wr.en = 1'b1;
				mem_wr.addr = q_sel_page;
				mem_wr.place = PLACE_SWAPPED;
				qcmd.shift = 1'b1;
				swap_inc = place != PLACE_SWAPPED;
				victim_load = 1'b1;
			end
			ST_FILL: begin
				commit = out_free;
				res_outcome = OUT_EVICT;
				res_evicted = victim_q;
				fault_inc = out_free;
				mem_wr.en = out_free;
				mem_wr.addr = page_q;
				mem_wr.place = PLACE_RESIDENT;
			end
			default: ;
		endcase
	end

	assign fault_nxt = (fault_inc && fault_q != FAULT_MAX) ? fault_q + 16'd1 : fault_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			swap_cnt_q <= '0;
			fault_q <= '0;
			lfsr_q <= LFSR_SEED;
			halted_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			fault_q <= fault_nxt;
			if (swap_inc) swap_cnt_q <= swap_cnt_q + 8'd1;
			if (lfsr_step) lfsr_q <= lfsr_nxt;
			if (halt_set) halted_q <= 1'b1;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) page_q <= page_number;
		if (idx_zero) begin
			idx_q <= '0;
		end else if (mod_done) begin
			idx_q <= mod_rem;
		end
		if (victim_load) victim_q <= q_sel_page;
		if (commit) begin
			outcome_q <= res_outcome;
			evicted_q <= res_evicted;
			fault_out_q <= fault_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign outcome = outcome_q;
	assign evicted_page = evicted_q;
	assign fault_total = fault_out_q;

	// Checks
	`PRA_ASSERT_NEXT(a_halt_sticky, clk, arst_n, halted_q, halted_q, "halt flag cleared")
	`PRA_ASSERT_NOW(a_evict_nonempty, clk, arst_n, state_q == ST_EVICT, |q_count, "no victim")
	`PRA_ASSERT_NOW(a_mod_done_div, clk, arst_n, mod_done, state_q == ST_DIV, "stray done")
	`PRA_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, q_count <= CW'(MAX_RESIDENT), "overfull")

endmodule

### rtl/pra_place_mem.sv
// Page place store: synchronous memory with per-entry valid bits.
module pra_place_mem
	import pra_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [PAGE_W-1:0] rd_addr,
	output logic [1:0] rd_place,
	input pmem_wr_t wr
);

	logic [1:0] mem_q [PLACE_DEPTH];
	logic [PLACE_DEPTH-1:0] vld_q;
	logic [1:0] data_s1;
	logic vld_s1;

	// Storage array, one write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.place;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_s1 <= mem_q[rd_addr];
		end
	end

	// Valid bits: an unwritten entry reads as never loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_place = vld_s1 ? data_s1 : PLACE_NEVER;

endmodule

### rtl/pra_queue.sv
// Resident page queue: shift cells with parallel compare.
module pra_queue
	import pra_pkg::*;
#(
	parameter int MAX_RESIDENT = MAX_RESIDENT_DEF
) (
	input logic clk,
	input logic arst_n,
	input qcmd_t cmd,
	input logic [((MAX_RESIDENT > 1) ? $clog2(MAX_RESIDENT) : 1)-1:0] idx,
	output logic [$clog2(MAX_RESIDENT+1)-1:0] count,
	output logic match_hit,
	output logic [((MAX_RESIDENT > 1) ? $clog2(MAX_RESIDENT) : 1)-1:0] match_idx,
	output logic [PAGE_W-1:0] sel_page
);

	localparam int CW = $clog2(MAX_RESIDENT + 1);
	localparam int IW = (MAX_RESIDENT > 1) ? $clog2(MAX_RESIDENT) : 1;

	logic [PAGE_W-1:0] cell_q [MAX_RESIDENT];
	logic [PAGE_W-1:0] up_cell [MAX_RESIDENT];
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] last;

	assign last = cnt_q - CW'(1);

	// Neighbour above each cell
	for (genvar g = 0; g < MAX_RESIDENT; g++) begin : g_up
		if (g + 1 < MAX_RESIDENT) begin : g_mid
			assign up_cell[g] = cell_q[g+1];
		end else begin : g_top
			assign up_cell[g] = cell_q[g];
		end
	end

	// Remove at idx and append at the back, or append into a free cell
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESIDENT; i++) begin
			if (cmd.shift) begin
				if (CW'(i) == last) begin
					cell_q[i] <= cmd.page;
				end else if (IW'(i) >= idx && CW'(i) < last) begin
					cell_q[i] <= up_cell[i];
				end
			end else if (cmd.push && CW'(i) == cnt_q) begin
				cell_q[i] <= cmd.page;
			end
		end
	end

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.push && !cmd.shift) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// Parallel compare, lowest matching cell wins
	always_comb begin
		match_hit = 1'b0;
		match_idx = '0;
		for (int i = MAX_RESIDENT - 1; i >= 0; i--) begin
			if (CW'(i) < cnt_q && cell_q[i] == cmd.page) begin
				match_hit = 1'b1;
				match_idx = IW'(i);
			end
		end
	end

	assign sel_page = cell_q[idx];
	assign count = cnt_q;

endmodule

### rtl/pra_mod.sv
// Restoring remainder unit: one dividend bit per cycle.
module pra_mod
	import pra_pkg::*;
#(
	parameter int MAX_RESIDENT = MAX_RESIDENT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [15:0] dividend,
	input logic [$clog2(MAX_RESIDENT+1)-1:0] divisor,
	output logic done,
	output logic [((MAX_RESIDENT > 1) ? $clog2(MAX_RESIDENT) : 1)-1:0] rem
);

	localparam int CW = $clog2(MAX_RESIDENT + 1);
	localparam int IW = (MAX_RESIDENT > 1) ? $clog2(MAX_RESIDENT) : 1;
	localparam int SW = $clog2(MOD_STEPS);

	logic [15:0] dvd_q;
	logic [CW:0] rem_q;
	logic [CW-1:0] div_q;
	logic [SW-1:0] step_q;
	logic busy_q;
	logic done_q;
	logic [CW:0] trial;

	// Bring down the next dividend bit and test against the divisor
	assign trial = {rem_q[CW-1:0], dvd_q[15]};

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[14:0], 1'b0};
			rem_q <= (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;
		end
	end

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + SW'(1);
				if (step_q == SW'(MOD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem = rem_q[IW-1:0];

endmodule

### dv/pra_result_check.sv
// Page reference checker: predicts every result of the page replacement block and compares.
`timescale 1ns / 1ps

module pra_result_check
	import pra_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [7:0] page_number,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] outcome,
	input logic [7:0] evicted_page,
	input logic [15:0] fault_total,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	input logic pready,
	output int results_awaited,
	output int mismatch_count
);

	localparam int FRAMES = MAX_RESIDENT_DEF;
	localparam logic [15:0] VICTIM_SEED = 16'hACE1;
	localparam logic [15:0] VICTIM_TAPS = 16'hB400;
	localparam logic [15:0] FAULTS_TOP = 16'hFFFF;

	typedef struct packed {
		logic [1:0] outcome;
		logic [7:0] evicted;
		logic [15:0] faults;
	} page_result_t;

	// Predicted block state
	logic [1:0] page_where [256];
	logic [7:0] frame_queue [FRAMES];
	int unsigned frames_used;
	int unsigned swap_used;
	logic [15:0] faults;
	logic [15:0] victim_lfsr;
	bit halted;

	// Register copies
	logic [4:0] frame_limit_reg;
	logic [7:0] swap_limit_reg;
	logic [1:0] policy;

	page_result_t awaited_results [$];
	page_result_t oldest;
	int errs = 0;

	// frame limit clamped to 1..FRAMES
	function automatic int unsigned usable_frames();
		if (frame_limit_reg == 0)
			return 1;
		if (frame_limit_reg > FRAMES)
			return FRAMES;
		return frame_limit_reg;
	endfunction

	function automatic void drop_frame(input int unsigned idx);
		for (int unsigned i = idx; i + 1 < frames_used; i++)
			frame_queue[i] = frame_queue[i + 1];
		frames_used--;
	endfunction

	function automatic void append_frame(input logic [7:0] pg);
		if (frames_used < FRAMES) begin
			frame_queue[frames_used] = pg;
			frames_used++;
		end
	endfunction

	function automatic void count_fault();
		if (faults != FAULTS_TOP)
			faults++;
	endfunction

	// pick a victim, take it out of the queue and mark it swapped
	function automatic logic [7:0] swap_out_victim();
		int unsigned idx;
		logic [7:0] victim;
		idx = 0;
		if (policy == MODE_RANDOM) begin
			// Galois LFSR steps once, then the index is taken from the new value
			victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ VICTIM_TAPS) : (victim_lfsr >> 1);
			idx = victim_lfsr % frames_used;
		end
		victim = frame_queue[idx];
		drop_frame(idx);
		page_where[victim] = PLACE_SWAPPED;
		return victim;
	endfunction

	// one page reference: update the state and return the result it gives
	function automatic page_result_t resolve_reference(input logic [7:0] pg);
		page_result_t r;
		bit full;
		bit found;
		r.outcome = OUT_HIT;
		r.evicted = '0;
		found = 1'b0;
		if (halted) begin
			r.outcome = OUT_ERROR;
		end else if (pg >= 1 && pg <= PAGE_COUNT) begin
			full = frames_used >= usable_frames();
			case (page_where[pg])
				PLACE_RESIDENT: begin
					// LRU hit moves the page to the back
					if (policy == MODE_LRU) begin
						for (int unsigned i = 0; i < frames_used; i++) begin
							if (!found && frame_queue[i] == pg) begin
								drop_frame(i);
								append_frame(pg);
								found = 1'b1;
							end
						end
					end
				end
				PLACE_SWAPPED: begin
					// reload from swap: swap occupancy unchanged
					if (full) begin
						r.evicted = swap_out_victim();
						r.outcome = OUT_EVICT;
					end else begin
						r.outcome = OUT_FILL;
					end
					append_frame(pg);
					page_where[pg] = PLACE_RESIDENT;
					count_fault();
				end
				default: begin
					// first touch: halts when memory and swap are both full
					if (full && swap_used >= swap_limit_reg) begin
						halted = 1'b1;
						r.outcome = OUT_ERROR;
					end else begin
						if (full) begin
							r.evicted = swap_out_victim();
							swap_used++;
							r.outcome = OUT_EVICT;
						end else begin
							r.outcome = OUT_FILL;
						end
						append_frame(pg);
						page_where[pg] = PLACE_RESIDENT;
						count_fault();
					end
				end
			endcase
		end
		r.faults = faults;
		return r;
	endfunction

	// watch config writes, requests and results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (page_where[i])
				page_where[i] = PLACE_NEVER;
			frames_used = 0;
			swap_used = 0;
			faults = '0;
			victim_lfsr = VICTIM_SEED;
			halted = 1'b0;
			frame_limit_reg = 5'd16;
			swap_limit_reg = 8'd255;
			policy = MODE_FIFO;
			awaited_results.delete();
			results_awaited <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_RESIDENT_LIMIT: frame_limit_reg = pwdata[4:0];
					REG_SWAP_LIMIT: swap_limit_reg = pwdata[7:0];
					REG_REPLACE_MODE: policy = pwdata[1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				awaited_results.insert(awaited_results.size(),
					resolve_reference(page_number));
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					errs++;
					$error("stray result outcome=%0d evicted_page=%0d fault_total=%0d",
						outcome, evicted_page, fault_total);
				end else begin
					oldest = awaited_results.pop_front();
					if (outcome !== oldest.outcome) begin
						errs++;
						$error("outcome: expected %0d, got %0d", oldest.outcome, outcome);
					end
					if (evicted_page !== oldest.evicted) begin
						errs++;
						$error("evicted_page: expected %0d, got %0d", oldest.evicted, evicted_page);
					end
					if (fault_total !== oldest.faults) begin
						errs++;
						$error("fault_total: expected %0d, got %0d", oldest.faults, fault_total);
					end
				end
			end
			results_awaited <= awaited_results.size();
			mismatch_count <= errs;
		end
	end

endmodule

### dv/page_replacement_with_swap_top_test.sv
// Testbench top for the page replacement block: request stimulus, register setup and verdict.
`timescale 1ns / 1ps

module page_replacement_with_swap_top_test;
	import pra_pkg::*;

	// spare policy code, behaves as FIFO
	localparam logic [1:0] MODE_SPARE = 2'd3;
	// page kept back for the final halt
	localparam logic [7:0] HALT_PAGE = 8'd254;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] page_number = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] outcome;
	logic [7:0] evicted_page;
	logic [15:0] fault_total;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	int results_awaited;
	int mismatch_count;

	bit page_used [256];
	int burst_left = 0;
	int rx_taken = 0;
	int rx_hold = 0;
	int rx_mode = 0;
	int rx_mode_left = 0;

	page_replacement_with_swap_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.page_number(page_number),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.outcome(outcome),
		.evicted_page(evicted_page),
		.fault_total(fault_total),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	pra_result_check i_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.page_number(page_number),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.outcome(outcome),
		.evicted_page(evicted_page),
		.fault_total(fault_total),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.results_awaited(results_awaited),
		.mismatch_count(mismatch_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: stall pattern of its own, plus one long hold-off
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			rx_taken++;
			if (rx_taken == 150)
				rx_hold = 300;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_mode_left = $urandom_range(16, 80);
			end
			rx_mode_left--;
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 9) < 7);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// offer one request; bursts of random length with random gaps between them
	task automatic offer_page(input logic [7:0] pg);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		page_number <= pg;
		page_used[pg] = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// drain: no request offered and every result taken
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_awaited != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input logic [4:0] frames, input logic [7:0] slots,
		input logic [1:0] policy);
		settle();
		write_reg(REG_RESIDENT_LIMIT, {27'd0, frames});
		write_reg(REG_SWAP_LIMIT, {24'd0, slots});
		write_reg(REG_REPLACE_MODE, {30'd0, policy});
	endtask

	// mostly a hot working set, some stray pages and out-of-range references;
	// without fresh only pages already seen, so a full swap never halts the block
	task automatic random_run(input int count, input bit fresh, input int ws_size);
		logic [7:0] hot [32];
		logic [7:0] old_pages [$];
		logic [7:0] pg;
		int r;
		for (int p = 1; p <= PAGE_COUNT; p++)
			if (page_used[p] && p != HALT_PAGE)
				old_pages.insert(old_pages.size(), 8'(p));
		for (int i = 0; i < ws_size; i++)
			hot[i] = fresh ? 8'($urandom_range(1, 253)) :
				old_pages[$urandom_range(0, old_pages.size() - 1)];
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				pg = hot[$urandom_range(0, ws_size - 1)];
			else if (r < 92)
				pg = fresh ? 8'($urandom_range(1, 253)) :
					old_pages[$urandom_range(0, old_pages.size() - 1)];
			else if (r < 96)
				pg = (fresh || page_used[255]) ? 8'd255 : hot[0];
			else
				pg = 8'd0;
			offer_page(pg);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// FIFO, two frames: out of range, fills, hit, evictions, swapped reload
		configure(5'd2, 8'd255, MODE_FIFO);
		offer_page(8'd0); offer_page(8'd1); offer_page(8'd255); offer_page(8'd1);
		offer_page(8'd2); offer_page(8'd1); offer_page(8'd128);
		// LRU: hits reorder the queue
		configure(5'd2, 8'd255, MODE_LRU);
		offer_page(8'd1); offer_page(8'd128); offer_page(8'd1); offer_page(8'd3);
		offer_page(8'd128);
		// random victim
		configure(5'd4, 8'd255, MODE_RANDOM);
		offer_page(8'd4); offer_page(8'd5); offer_page(8'd2); offer_page(8'd6);
		offer_page(8'd255);
		// frame limit zero clamps to one, swap limit zero, spare policy code
		configure(5'd0, 8'd0, MODE_SPARE);
		offer_page(8'd3); offer_page(8'd5); offer_page(8'd3);
		// limit above the frame count: swapped pages come back into free frames
		configure(5'd31, 8'd255, MODE_LRU);
		offer_page(8'd1); offer_page(8'd2); offer_page(8'd4); offer_page(8'd6);

		// random phases across settings
		configure(5'd16, 8'd255, MODE_FIFO);
		random_run(60, 1'b1, 20);
		configure(5'd5, 8'd255, MODE_LRU);
		random_run(60, 1'b1, 9);
		configure(5'd8, 8'd255, MODE_RANDOM);
		random_run(50, 1'b1, 12);
		configure(5'd1, 8'd0, MODE_LRU);
		random_run(30, 1'b0, 4);
		configure(5'd3, 8'd100, MODE_RANDOM);
		random_run(40, 1'b0, 6);
		configure(5'd16, 8'd255, MODE_LRU);
		random_run(60, 1'b1, 22);
		configure(5'd12, 8'd255, MODE_SPARE);
		random_run(40, 1'b1, 16);
		configure(5'd2, 8'd37, MODE_RANDOM);
		random_run(40, 1'b0, 5);
		configure(5'd6, 8'd255, MODE_FIFO);
		random_run(50, 1'b1, 10);

		// memory and swap full, new page: sticky error, then everything errors
		configure(5'd1, 8'd0, MODE_RANDOM);
		offer_page(HALT_PAGE); offer_page(8'd0); offer_page(8'd255); offer_page(8'd1);
		configure(5'd16, 8'd255, MODE_FIFO);
		offer_page(HALT_PAGE); offer_page(8'd2);

		in_valid <= 1'b0;
		do @(posedge clk); while (results_awaited != 0);
		repeat (30) @(posedge clk);
		if (mismatch_count == 0 && results_awaited == 0)
			$display("page_replacement_with_swap_top_test: PASS");
		else
			$display("page_replacement_with_swap_top_test: FAIL");
		$finish;
	end

	// run limit
	initial begin
		#3000000;
		$display("page_replacement_with_swap_top_test: FAIL");
		$finish;
	end

endmodule
